[src/button_press_duration_classifier_unit_assert.svh]
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BPDC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BPDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bpdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpdc_pkg;

	localparam int TIME_W   = 32;
	localparam int THRESH_W = 32;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX   = 2'd2;

	localparam logic [THRESH_W-1:0] LONG_RST  = 32'd1000;
	localparam logic [THRESH_W-1:0] RESET_RST = 32'd5000;
	localparam logic [THRESH_W-1:0] MAX_RST   = 32'd10000;

	// button phase codes
	localparam logic [1:0] PH_UNKNOWN  = 2'd0;
	localparam logic [1:0] PH_PRESSED  = 2'd1;
	localparam logic [1:0] PH_RELEASED = 2'd2;

	// press classification codes
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;
	localparam logic [1:0] KIND_RESET = 2'd3;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              button_level;
		logic              clear_request;
	} sample_t;

	typedef struct packed {
		logic [1:0] press_kind;
		logic       kind_ready;
		logic [1:0] button_phase;
		logic       release_event;
	} result_t;

	typedef struct packed {
		logic [THRESH_W-1:0] long_ms;
		logic [THRESH_W-1:0] reset_ms;
		logic [THRESH_W-1:0] max_ms;
	} thresh_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       pressed;
	} core_status_t;

endpackage

`default_nettype wire

[src/button_press_duration_classifier_unit.sv]
// Button press duration classifier.
// sample channel: valid/ready, one item per tick unless stalled, carrying the
// current millisecond time, debounced button level and consumer clear level.
// result channel: valid/ready, exactly one result item per sample item, in
// order, showing classification, ready flag, phase and a release marker.
// cfg port: cfg_we/cfg_index/cfg_data writes the long, reset and max
// thresholds; write only while no item is in flight.
// Pipeline: an accepted item sits in the sample register, and its result is
// loaded into the result register once that register is free or drained,
// at which point result_valid rises.
// Throughput: one item per cycle when not stalled; the limit is the single
// subtract and threshold compares that update the press state per item.
// Stall: when a waiting result sees result_ready low it is held; the sample
// register still takes one more item, then sample_ready drops.
// Reset: arst_n clears phase to unknown, kind to none, ready flag and clear
// edge tracking, and loads the thresholds 1000, 5000 and 10000 ms.
`timescale 1ns / 1ps
`default_nettype none

`include "button_press_duration_classifier_unit_assert.svh"

module button_press_duration_classifier_unit
	import bpdc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_ready,
	input  wire sample_t              sample,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output result_t                   result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [THRESH_W-1:0]  cfg_data
);

	logic         valid_s1;
	sample_t      sample_s1;
	logic         valid_s2;
	result_t      result_s2;
	logic         advance;
	logic         fire;
	thresh_t      thresh;
	result_t      core_result;
	core_status_t status;

	assign advance      = !valid_s2 || result_ready;
	assign fire         = valid_s1 && advance;
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= core_result;
		end
	end

	bpdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thresh    (thresh)
	);

	bpdc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.sample (sample_s1),
		.thresh (thresh),
		.result (core_result),
		.status (status)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

	`BPDC_ASSERT_NOW(a_release_consistent, clk, arst_n,
		result_valid && result.release_event,
		result.kind_ready && result.button_phase == PH_RELEASED && result.press_kind != KIND_NONE,
		"release item without ready classification")

	`BPDC_ASSERT_NEXT(a_release_follows, clk, arst_n,
		fire && status.pressed && !sample_s1.button_level,
		result_valid && result.release_event,
		"press end not reported as release")

	`BPDC_ASSERT_NOW(a_stall_only_when_full, clk, arst_n,
		!sample_ready,
		valid_s1 && valid_s2 && !result_ready,
		"sample side stalled with room in the pipeline")

endmodule

`default_nettype wire

[src/bpdc_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpdc_cfg_regs
	import bpdc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [THRESH_W-1:0]  cfg_data,
	output thresh_t                   thresh
);

	thresh_t thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.long_ms  <= LONG_RST;
			thresh_q.reset_ms <= RESET_RST;
			thresh_q.max_ms   <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LONG:  thresh_q.long_ms  <= cfg_data;
				REG_RESET: thresh_q.reset_ms <= cfg_data;
				REG_MAX:   thresh_q.max_ms   <= cfg_data;
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	assign thresh = thresh_q;

endmodule

`default_nettype wire

[src/bpdc_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpdc_core
	import bpdc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic fire,
	input  wire sample_t sample,
	input  wire thresh_t thresh,
	output result_t   result,
	output core_status_t status
);

	logic [1:0]        phase_q;
	logic [TIME_W-1:0] start_q;
	logic [1:0]        kind_q;
	logic              ready_q;
	logic              clear_seen_q;

	logic              is_pressed;
	logic              clr_edge;
	logic              ready_mid;
	logic              release_now;
	logic              press_now;
	logic [TIME_W-1:0] elapsed;
	logic [1:0]        kind_new;
	logic [1:0]        phase_d;
	logic [1:0]        kind_d;
	logic              ready_d;

	assign is_pressed  = (phase_q == PH_PRESSED);
	assign clr_edge    = sample.clear_request && !clear_seen_q;
	assign ready_mid   = clr_edge ? 1'b0 : ready_q;
	assign release_now = is_pressed && !sample.button_level;
	assign press_now   = !is_pressed && sample.button_level;
	assign elapsed     = sample.now_ms - start_q;

	// reset window wins over long, wrap of the time counter is modular
	always_comb begin
		priority if (elapsed >= thresh.reset_ms && elapsed < thresh.max_ms) begin
			kind_new = KIND_RESET;
		end else if (elapsed >= thresh.long_ms) begin
			kind_new = KIND_LONG;
		end else begin
			kind_new = KIND_SHORT;
		end
	end

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		ready_d = ready_mid;
		if (release_now) begin
			phase_d = PH_RELEASED;
			kind_d  = kind_new;
			ready_d = 1'b1;
		end else if (press_now) begin
			phase_d = PH_PRESSED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_UNKNOWN;
			start_q      <= '0;
			kind_q       <= KIND_NONE;
			ready_q      <= 1'b0;
			clear_seen_q <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			kind_q       <= kind_d;
			ready_q      <= ready_d;
			clear_seen_q <= sample.clear_request;
			if (press_now) begin
				start_q <= sample.now_ms;
			end
		end
	end

	assign result.press_kind    = kind_d;
	assign result.kind_ready    = ready_d;
	assign result.button_phase  = phase_d;
	assign result.release_event = release_now;

	assign status.phase   = phase_q;
	assign status.pressed = is_pressed;

endmodule

`default_nettype wire
